/* rtl/glpc_pkg.sv */
// ----------------------------------------------------------------------------
// glpc_pkg
// Shared types and constants of the grid lattice path counter: field widths,
// controller states and the command/status bundles between control and data.
// ----------------------------------------------------------------------------
package glpc_pkg;

	localparam int GLPC_MAX_ROWS = 32;
	localparam int GLPC_MAX_COLS = 32;
	localparam int GLPC_DIM_W    = 6;
	localparam int GLPC_COUNT_W  = 64;
	localparam logic GLPC_JUMP_RESET = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW_RD,
		ST_SUM,
		ST_ADD,
		ST_WR,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic item_start;
		logic row_start;
		logic rd_en;
		logic sum_en;
		logic add_en;
		logic wr_en;
		logic first_row;
		logic last_col;
		logic corner;
		logic emit;
		logic emit_empty;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic res_busy;
	} sts_t;

endpackage

/* rtl/glpc_ifs.sv */
// ----------------------------------------------------------------------------
// glpc interfaces
// Valid/ready channels for grid items, path count results and the mode write.
// ----------------------------------------------------------------------------
interface glpc_item_if import glpc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [GLPC_DIM_W-1:0] grid_rows;
	logic [GLPC_DIM_W-1:0] grid_cols;

	modport source(output valid, grid_rows, grid_cols, input ready);
	modport sink(input valid, grid_rows, grid_cols, output ready);
endinterface

interface glpc_result_if import glpc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [GLPC_COUNT_W-1:0] path_count;
	logic                    count_overflow;

	modport source(output valid, path_count, count_overflow, input ready);
	modport sink(input valid, path_count, count_overflow, output ready);
endinterface

interface glpc_cfg_if ();
	logic valid;
	logic ready;
	logic jump_mode;

	modport source(output valid, jump_mode, input ready);
	modport sink(input valid, jump_mode, output ready);
endinterface

/* rtl/glpc_ram.sv */
// ----------------------------------------------------------------------------
// glpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glpc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/glpc_ctrl.sv */
// ----------------------------------------------------------------------------
// glpc_ctrl
// Sequencer: takes an item, walks rows and columns from the bottom-right
// corner backwards, three steps per position, and hands off the result.
// ----------------------------------------------------------------------------
module glpc_ctrl import glpc_pkg::*; #(
	parameter int MAX_ROWS = GLPC_MAX_ROWS,
	parameter int MAX_COLS = GLPC_MAX_COLS,
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	glpc_item_if.sink     item,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic [CW-1:0] rd_addr,
	output logic [CW-1:0] wr_addr
);

	state_t        state_q, state_d;
	logic [RW-1:0] r_q, r_d, n_last_q, n_last_d;
	logic [CW-1:0] c_q, c_d, m_last_q, m_last_d;
	logic          empty_q, empty_d;
	logic          first_row, last_col;

	assign first_row = (r_q == n_last_q);
	assign last_col  = (c_q == m_last_q);
	assign wr_addr   = c_q;
	assign item.ready = (state_q == ST_IDLE);

	// State and position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			r_q      <= '0;
			c_q      <= '0;
			n_last_q <= '0;
			m_last_q <= '0;
			empty_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			r_q      <= r_d;
			c_q      <= c_d;
			n_last_q <= n_last_d;
			m_last_q <= m_last_d;
			empty_q  <= empty_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		c_d      = c_q;
		n_last_d = n_last_q;
		m_last_d = m_last_q;
		empty_d  = empty_q;
		rd_addr  = c_q;
		cmd            = '0;
		cmd.first_row  = first_row;
		cmd.last_col   = last_col;
		cmd.corner     = first_row && last_col;

		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					// clamp oversized grids to the storage size
					if (32'(item.grid_rows) > MAX_ROWS) begin
						n_last_d = RW'(MAX_ROWS - 1);
					end else begin
						n_last_d = RW'(item.grid_rows - GLPC_DIM_W'(1));
					end
					if (32'(item.grid_cols) > MAX_COLS) begin
						m_last_d = CW'(MAX_COLS - 1);
					end else begin
						m_last_d = CW'(item.grid_cols - GLPC_DIM_W'(1));
					end
					empty_d = (item.grid_rows == '0) || (item.grid_cols == '0);
					r_d = n_last_d;
					c_d = m_last_d;
					if (empty_d) begin
						state_d = ST_EMIT;
					end else begin
						cmd.item_start = 1'b1;
						state_d = ST_ROW_RD;
					end
				end
			end
			ST_ROW_RD: begin
				// fetch the last column of the row below
				cmd.row_start = 1'b1;
				cmd.rd_en     = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_en = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.wr_en = 1'b1;
				if (c_q == '0) begin
					if (r_q == '0) begin
						state_d = ST_EMIT;
					end else begin
						r_d = r_q - RW'(1);
						c_d = m_last_q;
						state_d = ST_ROW_RD;
					end
				end else begin
					// prefetch the next column to the left
					rd_addr   = c_q - CW'(1);
					cmd.rd_en = 1'b1;
					c_d = c_q - CW'(1);
					state_d = ST_SUM;
				end
			end
			ST_EMIT: begin
				if (!sts.res_busy) begin
					cmd.emit       = 1'b1;
					cmd.emit_empty = empty_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/glpc_dp.sv */
// ----------------------------------------------------------------------------
// glpc_dp
// Datapath: row buffers of the row below, the 64-bit adders, the
// running row value, the overflow flag, the mode register and the result.
// ----------------------------------------------------------------------------
module glpc_dp import glpc_pkg::*; #(
	parameter int MAX_COLS = GLPC_MAX_COLS,
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	glpc_cfg_if.sink      cfg,
	glpc_result_if.source result,
	input  cmd_t          cmd,
	input  logic [CW-1:0] rd_addr,
	input  logic [CW-1:0] wr_addr,
	output sts_t          sts
);

	localparam int W = GLPC_COUNT_W;

	logic         jump_q;
	logic         ovf_q;
	logic [W-1:0] x_q, s1_q, z_q, t_hold_q, v_q, y_q;
	logic [W-1:0] c_rd, t_rd, c_wr, t_wr;
	logic [W-1:0] x_sel;
	logic [W:0]   sum_xy, sum_sz, sum_col, sum_diag, sum_row;
	logic         res_valid_q, res_ovf_q;
	logic [W-1:0] res_count_q;

	// Previous-row column values (column sums in jump mode, counts otherwise)
	glpc_ram #(.WIDTH(W), .DEPTH(MAX_COLS)) u_col_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (c_wr),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (c_rd)
	);

	// Previous-row diagonal values (inclusive diagonal sums, counts otherwise)
	glpc_ram #(.WIDTH(W), .DEPTH(MAX_COLS)) u_diag_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (wr_addr),
		.wr_data (t_wr),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (t_rd)
	);

	// Adders with carry out
	assign x_sel    = cmd.first_row ? '0 : c_rd;
	assign sum_xy   = {1'b0, x_sel} + {1'b0, y_q};
	assign sum_sz   = {1'b0, s1_q} + {1'b0, z_q};
	assign sum_col  = {1'b0, x_q} + {1'b0, v_q};
	assign sum_diag = {1'b0, v_q} + {1'b0, z_q};
	assign sum_row  = {1'b0, y_q} + {1'b0, v_q};

	assign c_wr = jump_q ? sum_col[W-1:0] : v_q;
	assign t_wr = jump_q ? sum_diag[W-1:0] : v_q;

	// Mode register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_q <= GLPC_JUMP_RESET;
		end else if (cfg.valid) begin
			jump_q <= cfg.jump_mode;
		end
	end

	// Operand and sum registers
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			x_q      <= x_sel;
			s1_q     <= sum_xy[W-1:0];
			z_q      <= (cmd.first_row || cmd.last_col) ? '0 : t_hold_q;
			t_hold_q <= t_rd;
		end
		if (cmd.add_en) begin
			v_q <= cmd.corner ? W'(1) : sum_sz[W-1:0];
		end
		// right neighbor in single-step mode, running row sum in jump mode
		if (cmd.row_start) begin
			y_q <= '0;
		end else if (cmd.wr_en) begin
			y_q <= jump_q ? sum_row[W-1:0] : v_q;
		end
	end

	// Overflow flag of the current item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (cmd.item_start) begin
			ovf_q <= 1'b0;
		end else if (cmd.sum_en) begin
			ovf_q <= ovf_q | sum_xy[W];
		end else if (cmd.add_en) begin
			ovf_q <= ovf_q | (sum_sz[W] & ~cmd.corner);
		end else if (cmd.wr_en && jump_q) begin
			ovf_q <= ovf_q | sum_col[W] | sum_diag[W] | sum_row[W];
		end
	end

	// Result register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_count_q <= cmd.emit_empty ? '0 : v_q;
			res_ovf_q   <= cmd.emit_empty ? 1'b0 : ovf_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.path_count     = res_count_q;
	assign result.count_overflow = res_ovf_q;
	assign sts.res_busy          = res_valid_q && !result.ready;

endmodule

/* rtl/grid_lattice_path_counter_top.sv */
// Each position takes three steps on the 64-bit adder chain, plus one buffer
// read at the start of each row. One item is in work at a time; the
// next one is taken once the result has moved to the output register.
// Reset clears control state and sets jump_mode to 1; the row buffers are not cleared.
// ----------------------------------------------------------------------------
// grid_lattice_path_counter_top
// Counts right/down/diagonal lattice paths over a grid, single-step or jump.
// ----------------------------------------------------------------------------
module grid_lattice_path_counter_top import glpc_pkg::*; #(
	parameter int MAX_ROWS = GLPC_MAX_ROWS,
	parameter int MAX_COLS = GLPC_MAX_COLS
) (
	input  logic          clk,
	input  logic          arst_n,
	glpc_item_if.sink     item,
	glpc_result_if.source result,
	glpc_cfg_if.sink      cfg
);

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	cmd_t          cmd;
	sts_t          sts;
	logic [CW-1:0] rd_addr;
	logic [CW-1:0] wr_addr;

	// Sequencer
	glpc_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.sts     (sts),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr)
	);

	// Arithmetic and storage
	glpc_dp #(.MAX_COLS(MAX_COLS)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.result  (result),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.sts     (sts)
	);

endmodule
